[rtl/iole_pkg.sv]
// Shared types and constants for the indexed ordered list engine.
`timescale 1ns / 1ps

package iole_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam int IN_TDATA_BITS  = 40;
    localparam int OUT_TDATA_BITS = 48;

    typedef enum logic [2:0] {
        CMD_PREPEND   = 3'd0,
        CMD_APPEND    = 3'd1,
        CMD_INSERT    = 3'd2,
        CMD_REMOVE_AT = 3'd3,
        CMD_REMOVE_V  = 3'd4,
        CMD_READ      = 3'd5,
        CMD_FIND      = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_RANGE  = 2'd2,
        ST_ABSENT = 2'd3
    } t_status;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic rm;
    } t_cell_ctl;

endpackage

[rtl/indexed_ordered_list_engine.sv]
// Top level of the indexed ordered list engine: command sequencer and cell row.
`timescale 1ns / 1ps

// An ordered list of up to DEPTH words kept in a row of cells, position 0
// first. For each command the transaction is accepted, then every cell
// compares its entry with the command word, then the row shifts or loads
// in one step and the result is registered. A stalled result holds that
// last step; the next command is accepted while the result waits. Insertions
// shift later cells up, removals shift them down. Each command yields exactly
// one result transaction with word, position, status and the new length.
module indexed_ordered_list_engine #(
    parameter int DEPTH     = iole_pkg::DEPTH_DEF,
    parameter int WORD_BITS = iole_pkg::WORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // cmd[2:0], position[7:3], word_in[39:8]
    input  logic [iole_pkg::IN_TDATA_BITS-1:0]   i_s_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // word_out[31:0], position_out[35:32], status[37:36], count[42:38], zero fill
    output logic [iole_pkg::OUT_TDATA_BITS-1:0]  o_m_tdata
);
    import iole_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (LW > 5) ? LW : 5;

    typedef enum logic [1:0] {S_IDLE, S_CMP, S_ACT} t_state;

    t_state               r_state;
    logic [2:0]           r_cmd;
    logic [4:0]           r_pos;
    logic [WORD_BITS-1:0] r_word;
    logic [LW-1:0]        r_len;
    logic                 r_ovalid;
    logic [31:0]          r_o_word;
    logic [3:0]           r_o_pos;
    logic [1:0]           r_o_status;
    logic [4:0]           r_o_count;

    logic [LW-1:0]        n_len;
    logic [31:0]          n_o_word;
    logic [CW-1:0]        n_o_pos;
    t_status              n_o_status;

    t_cell_ctl            w_ctl;
    logic [PW-1:0]        w_cell_pos;
    logic [WORD_BITS-1:0] w_entry [DEPTH];
    logic [DEPTH-1:0]     w_first;
    logic                 w_seen  [DEPTH+1];

    logic                 w_accept;
    logic                 w_act;
    logic                 w_full;
    logic [CW-1:0]        w_pos_ext;
    logic [CW-1:0]        w_len_ext;
    logic [CW-1:0]        w_at;
    logic [PW-1:0]        w_found_idx;
    logic [PW-1:0]        w_sel_idx;
    logic [WORD_BITS-1:0] w_sel_word;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign w_act      = (r_state == S_ACT) && (!r_ovalid || i_m_tready);

    assign w_full    = (r_len >= LW'(DEPTH));
    assign w_pos_ext = CW'(r_pos);
    assign w_len_ext = CW'(r_len);
    assign w_seen[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [WORD_BITS-1:0] w_left;
            logic [WORD_BITS-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = r_word;
            end else begin : g_mid_l
                assign w_left = w_entry[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_right = w_entry[g];
            end else begin : g_mid_r
                assign w_right = w_entry[g+1];
            end
            iole_cell #(
                .INDEX     (g),
                .WORD_BITS (WORD_BITS),
                .PW        (PW),
                .LW        (LW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_pos   (w_cell_pos),
                .i_len   (r_len),
                .i_word  (r_word),
                .i_left  (w_left),
                .i_right (w_right),
                .i_seen  (w_seen[g]),
                .o_seen  (w_seen[g+1]),
                .o_first (w_first[g]),
                .o_entry (w_entry[g])
            );
        end
    endgenerate

    always_comb begin
        w_found_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_first[i]) begin
                w_found_idx = w_found_idx | PW'(i);
            end
        end
    end

    always_comb begin
        w_sel_idx = ((r_cmd == CMD_REMOVE_V) || (r_cmd == CMD_FIND)) ? w_found_idx
                                                                     : PW'(r_pos);
        w_sel_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (PW'(i) == w_sel_idx) begin
                w_sel_word = w_sel_word | w_entry[i];
            end
        end
    end

    always_comb begin
        w_ctl      = '0;
        w_ctl.cmp  = (r_state == S_CMP);
        n_len      = r_len;
        n_o_word   = '0;
        n_o_pos    = '0;
        n_o_status = ST_OK;
        w_at       = '0;
        unique case (r_cmd)
            CMD_PREPEND, CMD_APPEND, CMD_INSERT: begin
                w_at = (r_cmd == CMD_PREPEND) ? '0 :
                       (r_cmd == CMD_APPEND)  ? w_len_ext : w_pos_ext;
                if (w_full) begin
                    n_o_status = ST_FULL;
                end else if (w_at > w_len_ext) begin
                    n_o_status = ST_RANGE;
                end else begin
                    w_ctl.ins = w_act;
                    n_len     = r_len + LW'(1);
                    n_o_pos   = w_at;
                end
            end
            CMD_REMOVE_AT, CMD_READ: begin
                if (w_pos_ext >= w_len_ext) begin
                    n_o_status = ST_RANGE;
                end else begin
                    n_o_word = 32'(w_sel_word);
                    n_o_pos  = w_pos_ext;
                    if (r_cmd == CMD_REMOVE_AT) begin
                        w_ctl.rm = w_act;
                        n_len    = r_len - LW'(1);
                    end
                end
            end
            CMD_REMOVE_V, CMD_FIND: begin
                if (!w_seen[DEPTH]) begin
                    n_o_status = ST_ABSENT;
                end else begin
                    n_o_pos = CW'(w_found_idx);
                    if (r_cmd == CMD_REMOVE_V) begin
                        n_o_word = 32'(w_sel_word);
                        w_ctl.rm = w_act;
                        n_len    = r_len - LW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
        w_cell_pos = w_ctl.ins ? PW'(w_at) : w_sel_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_m_tready && !w_act) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd   <= i_s_tdata[2:0];
                        r_pos   <= i_s_tdata[7:3];
                        r_word  <= WORD_BITS'(i_s_tdata[39:8]);
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_ACT;
                end
                S_ACT: begin
                    if (w_act) begin
                        r_len      <= n_len;
                        r_ovalid   <= 1'b1;
                        r_o_word   <= n_o_word;
                        r_o_pos    <= n_o_pos[3:0];
                        r_o_status <= n_o_status;
                        r_o_count  <= 5'(n_len);
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {5'd0, r_o_count, r_o_status, r_o_pos, r_o_word};

`ifndef ASSERT_OFF
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(DEPTH))
        else $error("list length above depth");

    a_first_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACT) |-> $onehot0(w_first))
        else $error("more than one first match");

    a_act_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_act |=> (o_m_tvalid && (r_state == S_IDLE)))
        else $error("action step did not post a result");

    a_accept_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_CMP))
        else $error("accepted command did not start compare");
`endif

endmodule

[rtl/iole_cell.sv]
// One list cell: holds an entry, shifts with its neighbors, flags a match.
`timescale 1ns / 1ps

module iole_cell #(
    parameter int INDEX     = 0,
    parameter int WORD_BITS = 32,
    parameter int PW        = 4,
    parameter int LW        = 5
) (
    input  logic                 i_clk,
    input  iole_pkg::t_cell_ctl  i_ctl,
    input  logic [PW-1:0]        i_pos,
    input  logic [LW-1:0]        i_len,
    input  logic [WORD_BITS-1:0] i_word,
    input  logic [WORD_BITS-1:0] i_left,
    input  logic [WORD_BITS-1:0] i_right,
    input  logic                 i_seen,
    output logic                 o_seen,
    output logic                 o_first,
    output logic [WORD_BITS-1:0] o_entry
);
    import iole_pkg::*;

    localparam logic [PW-1:0] MY_POS = PW'(INDEX);
    localparam logic [LW-1:0] MY_LEN = LW'(INDEX);

    logic [WORD_BITS-1:0] r_entry;
    logic                 r_match;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_match <= (r_entry == i_word) && (MY_LEN < i_len);
        end
        if (i_ctl.ins) begin
            if (MY_POS == i_pos) begin
                r_entry <= i_word;
            end else if (MY_POS > i_pos) begin
                r_entry <= i_left;
            end
        end else if (i_ctl.rm) begin
            if (MY_POS >= i_pos) begin
                r_entry <= i_right;
            end
        end
    end

    assign o_first = r_match && !i_seen;
    assign o_seen  = r_match || i_seen;
    assign o_entry = r_entry;

endmodule
